>>> hdl/cobp_pkg.sv
// Package for the cascaded one-pole band-pass unit.
// Holds the sequencer state type, the shared-unit control struct and fixed constants.
// No dependencies.
package cobp_pkg;

  // extra fraction bits carried by every stage value
  localparam int STATE_FRAC = 8;
  // width of the pole count register
  localparam int POLE_W = 4;
  // pole count after reset
  localparam logic [POLE_W-1:0] POLE_RESET = 4'd4;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_UPD,
    ST_OUT
  } cobp_state_t;

  // control for the shared multiply and update unit
  typedef struct packed {
    logic mul_en;   // capture stage value and register the product
    logic use_low;  // second cascade: use the low gain
  } cobp_mac_ctrl_t;

endpackage

>>> hdl/cascaded_one_pole_bandpass_unit.sv
// Cascaded one-pole band-pass: top level with sequencer, stage RAM and shared stage unit.
// Depends on cobp_pkg, cobp_ram and cobp_mac.
//
// Each accepted beat runs pole_count (capped at MAX_STAGES) one-pole stages with the high
// gain, then as many with the low gain, on one shared multiply unit, and returns first minus
// second cascade at sample scale. Each stage has two steps: ST_MUL takes the registered RAM
// read and registers the product, ST_UPD forms the update and writes it back. After the
// last stage ST_OUT loads the result register, and the next beat is taken in ST_IDLE. An
// unconnected, out-of-range or zero-pole item goes from ST_IDLE straight to ST_OUT and
// leaves the stage values and their valid bits alone. The input is ready only between
// items; a finished result waits in the output register while the next beat is accepted,
// and if that register is still full when the next result is done, the sequencer holds
// until it is taken. Stage values live in one RAM with a valid bit per entry that reset
// clears, so there is no clearing pass. Write pole_count only while the unit is idle.
module cascaded_one_pole_bandpass_unit
  import cobp_pkg::*;
#(
  parameter int MAX_STAGES     = 8,
  parameter int NUM_CHANNELS   = 2,
  parameter int SAMPLE_BITS    = 24,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_channel,
  input  logic                          in_connected,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [GAIN_FRAC_BITS:0]       in_high_gain,
  input  logic [GAIN_FRAC_BITS:0]       in_low_gain,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_channel,
  output logic signed [SAMPLE_BITS:0]   out_band,
  // configuration
  input  logic                          cfg_we,
  input  logic [POLE_W-1:0]             cfg_wdata
);

  localparam int STATE_W = SAMPLE_BITS + STATE_FRAC;
  localparam int DEPTH   = 2 * NUM_CHANNELS * MAX_STAGES;
  localparam int AW      = $clog2(DEPTH);
  localparam int SW      = $clog2(MAX_STAGES + 1);
  localparam logic [GAIN_FRAC_BITS:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

  // RAM address of one stage value
  function automatic logic [AW-1:0] addr_of(input logic casc, input logic ch,
                                            input logic [SW-1:0] stage);
    addr_of = AW'((32'(casc) * NUM_CHANNELS + 32'(ch)) * MAX_STAGES + 32'(stage));
  endfunction

  cobp_state_t state_r, state_nxt;

  logic [POLE_W-1:0]         pole_count_r;
  logic [DEPTH-1:0]          valid_r, valid_nxt;
  logic                      ch_r, ch_nxt;
  logic                      casc_r, casc_nxt;
  logic [SW-1:0]             stage_r, stage_nxt;
  logic [SW-1:0]             n_r, n_nxt;
  logic signed [STATE_W-1:0] x_r, x_nxt;
  logic signed [STATE_W-1:0] a_r, a_nxt;
  logic [GAIN_FRAC_BITS:0]   gh_r, gh_nxt;
  logic [GAIN_FRAC_BITS:0]   gl_r, gl_nxt;
  logic signed [SAMPLE_BITS:0] band_r, band_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic                        out_channel_r;
  logic signed [SAMPLE_BITS:0] out_band_r;

  logic                      accept;
  logic                      active_in;
  logic [SW-1:0]             n_in;
  logic                      last_stage;
  logic                      slot_free;
  logic                      out_load;
  logic                      ram_we, ram_re;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [STATE_W-1:0]        ram_rdata;
  logic signed [STATE_W-1:0] s_cur, s_new;
  logic signed [STATE_W:0]   band_diff;
  cobp_mac_ctrl_t            mac_ctrl;

  // item decode
  always_comb begin
    accept     = in_valid && in_ready;
    n_in       = (32'(pole_count_r) > MAX_STAGES) ? SW'(MAX_STAGES) : SW'(pole_count_r);
    active_in  = in_connected && (32'(in_channel) < NUM_CHANNELS) && (n_in != '0);
    last_stage = (stage_r + SW'(1)) == n_r;
    slot_free  = !out_valid_r || out_ready;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = active_in ? ST_MUL : ST_OUT;
        end
      end
      ST_MUL:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = (last_stage && casc_r) ? ST_OUT : ST_MUL;
      ST_OUT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready         = 1'b0;
    mac_ctrl.mul_en  = 1'b0;
    mac_ctrl.use_low = casc_r;
    ram_we           = 1'b0;
    out_load         = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MUL:  mac_ctrl.mul_en = 1'b1;
      ST_UPD:  ram_we = 1'b1;
      ST_OUT:  out_load = slot_free;
      default: in_ready = 1'b0;
    endcase
    ram_re = (state_nxt == ST_MUL);
  end

  // working registers
  always_comb begin
    ch_nxt    = ch_r;
    casc_nxt  = casc_r;
    stage_nxt = stage_r;
    n_nxt     = n_r;
    x_nxt     = x_r;
    a_nxt     = a_r;
    gh_nxt    = gh_r;
    gl_nxt    = gl_r;
    band_nxt  = band_r;
    valid_nxt = valid_r;
    band_diff = $signed({a_r[STATE_W-1], a_r}) - $signed({s_new[STATE_W-1], s_new});
    if (accept) begin
      ch_nxt    = in_channel;
      casc_nxt  = 1'b0;
      stage_nxt = '0;
      n_nxt     = n_in;
      x_nxt     = $signed({in_sample, {STATE_FRAC{1'b0}}});
      gh_nxt    = (in_high_gain > GAIN_ONE) ? GAIN_ONE : in_high_gain;
      gl_nxt    = (in_low_gain > GAIN_ONE) ? GAIN_ONE : in_low_gain;
      band_nxt  = '0;
    end
    if (state_r == ST_UPD) begin
      x_nxt              = s_new;
      valid_nxt[wr_addr] = 1'b1;
      if (last_stage) begin
        stage_nxt = '0;
        if (!casc_r) begin
          casc_nxt = 1'b1;
          a_nxt    = s_new;
        end else begin
          band_nxt = band_diff[STATE_W:STATE_FRAC];
        end
      end else begin
        stage_nxt = stage_r + SW'(1);
      end
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pole_count_r <= POLE_RESET;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        pole_count_r <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    ch_r    <= ch_nxt;
    casc_r  <= casc_nxt;
    stage_r <= stage_nxt;
    n_r     <= n_nxt;
    x_r     <= x_nxt;
    a_r     <= a_nxt;
    gh_r    <= gh_nxt;
    gl_r    <= gl_nxt;
    band_r  <= band_nxt;
    if (out_load) begin
      out_channel_r <= ch_r;
      out_band_r    <= band_r;
    end
  end

  // stage value storage; entries never written read as zero
  assign wr_addr = addr_of(casc_r, ch_r, stage_r);
  assign rd_addr = addr_of(casc_nxt, ch_nxt, stage_nxt);
  assign s_cur   = valid_r[wr_addr] ? $signed(ram_rdata) : '0;

  cobp_ram #(
    .WIDTH (STATE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (s_new),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  cobp_mac #(
    .STATE_W        (STATE_W),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
  ) u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .x         (x_r),
    .s         (s_cur),
    .high_gain (gh_r),
    .low_gain  (gl_r),
    .s_new     (s_new)
  );

  assign out_valid   = out_valid_r;
  assign out_channel = out_channel_r;
  assign out_band    = out_band_r;

`ifndef SYNTHESIS
  // an update is always followed by the next product or by the result
  a_upd_next: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |=> (state_r == ST_MUL || state_r == ST_OUT))
    else $error("update not followed by product or result");

  // the stage counter stays below the pole count while filtering
  a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (stage_r < n_r))
    else $error("stage index beyond pole count");

  // an unconnected beat goes straight to the result and leaves the valid bits alone
  a_unconn_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !in_connected) |=> (state_r == ST_OUT && $stable(valid_r)))
    else $error("unconnected beat entered the filter");
`endif

endmodule

>>> hdl/cobp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the per-channel stage values. No dependencies.
module cobp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/cobp_mac.sv
// Shared one-pole stage unit: registers g*(x-s), then forms s + floor(p / 2^GAIN_FRAC_BITS).
// Depends on cobp_pkg for the control struct.
module cobp_mac
  import cobp_pkg::*;
#(
  parameter int STATE_W        = 32,
  parameter int GAIN_FRAC_BITS = 16
) (
  input  logic                        clk,
  input  cobp_mac_ctrl_t              ctrl,
  input  logic signed [STATE_W-1:0]   x,
  input  logic signed [STATE_W-1:0]   s,
  input  logic [GAIN_FRAC_BITS:0]     high_gain,
  input  logic [GAIN_FRAC_BITS:0]     low_gain,
  output logic signed [STATE_W-1:0]   s_new
);

  localparam int D_W = STATE_W + 1;
  localparam int P_W = D_W + GAIN_FRAC_BITS + 2;

  logic signed [STATE_W-1:0] s_r;
  logic signed [P_W-1:0]     prod_r;
  logic [GAIN_FRAC_BITS:0]   gain;
  logic signed [D_W-1:0]     diff;
  logic signed [P_W-1:0]     prod_nxt;

  // gain select and exact difference
  always_comb begin
    gain     = ctrl.use_low ? low_gain : high_gain;
    diff     = $signed({x[STATE_W-1], x}) - $signed({s[STATE_W-1], s});
    prod_nxt = $signed({1'b0, gain}) * diff;
  end

  // product register
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      s_r    <= s;
      prod_r <= prod_nxt;
    end
  end

  // arithmetic shift drops the low bits, i.e. floors
  assign s_new = STATE_W'(s_r + (prod_r >>> GAIN_FRAC_BITS));

endmodule
